@@ rtl/odt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_pkg
// Shared types and constants for the one-shot deadline table.
// ----------------------------------------------------------------------------
package odt_pkg;

   localparam int MAX_TASKS = 16;
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
   localparam int TIME_W    = 32;
   localparam int ID_W      = 8;
   localparam int OP_W      = 2;

   localparam logic [TIME_W-1:0]  MS_TO_US  = TIME_W'(1000);
   localparam logic [COUNT_W-1:0] TABLE_MAX = COUNT_W'(MAX_TASKS);

   localparam logic [OP_W-1:0] OP_SCHED_US = 2'd0;
   localparam logic [OP_W-1:0] OP_SCHED_MS = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN      = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   task_id;
   } odt_entry_type;

   // per-cell load controls, highest priority first
   typedef struct packed {
      logic take_new;
      logic take_head;
      logic shift;
   } odt_cell_ctl_type;

endpackage

@@ rtl/one_shot_deadline_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_deadline_table_core
// Ordered table of one-shot tasks held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | op, now, task_id, delay
//  rsp     | out       | rsp_valid/rsp_ready   | accepted, fired, task_out, last
//
//  schedule: delay scaling at acceptance, then in ST_SCHED the deadline add,
//  the slot load and the result in the output register; a stalled rsp side
//  holds ST_SCHED, and no new request is taken until the result is registered
//  run: one stored entry per cycle while the scan is not held, the head cell
//  is examined and the row shifts left, then the closing result is registered;
//  a stalled rsp side holds the scan whenever a second due task must leave
//  reset (synchronous, active high) clears entry_count and the control state;
//  slot contents are not cleared
// ----------------------------------------------------------------------------
module one_shot_deadline_table_core (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [odt_pkg::OP_W-1:0]    req_op,
   input  logic [odt_pkg::TIME_W-1:0]  req_now,
   input  logic [odt_pkg::ID_W-1:0]    req_task_id,
   input  logic [odt_pkg::TIME_W-1:0]  req_delay,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_accepted,
   output logic                        rsp_fired,
   output logic [odt_pkg::ID_W-1:0]    rsp_task_out,
   output logic                        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCHED = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // transaction fields captured at acceptance
   logic [odt_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [odt_pkg::TIME_W-1:0]  delay_ff, delay_in;
   logic [odt_pkg::ID_W-1:0]    id_ff, id_in;

   // table bookkeeping
   logic [odt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [odt_pkg::COUNT_W-1:0] remain_ff, remain_in;
   logic [odt_pkg::COUNT_W-1:0] kept_ff, kept_in;

   // one due task held back until we know whether it is the final one
   logic                        pend_valid_ff, pend_valid_in;
   logic [odt_pkg::ID_W-1:0]    pend_id_ff, pend_id_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_accepted_ff, rsp_accepted_in;
   logic                        rsp_fired_ff, rsp_fired_in;
   logic [odt_pkg::ID_W-1:0]    rsp_task_out_ff, rsp_task_out_in;
   logic                        rsp_last_ff, rsp_last_in;

   // cell row
   odt_pkg::odt_entry_type    cell_entry [odt_pkg::MAX_TASKS];
   odt_pkg::odt_entry_type    cell_right [odt_pkg::MAX_TASKS];
   odt_pkg::odt_cell_ctl_type cell_ctl   [odt_pkg::MAX_TASKS];
   odt_pkg::odt_entry_type    new_entry;
   odt_pkg::odt_entry_type    head_entry;

   logic                        req_fire;
   logic                        out_free;
   logic                        head_due;
   logic                        scan_step;
   logic                        sched_load;
   logic [odt_pkg::COUNT_W-1:0] tail_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // head of the row is always cell zero
   assign head_entry = cell_entry[0];
   assign head_due   = (now_ff >= head_entry.deadline);

   // a kept entry goes behind the unexamined and the already kept entries
   assign tail_pos = remain_ff - odt_pkg::COUNT_W'(1) + kept_ff;

   // a second due task needs the output register to free the held one
   assign scan_step = (state_ff == ST_SCAN) && (remain_ff != '0) &&
                      (!head_due || !pend_valid_ff || out_free);

   assign sched_load = (state_ff == ST_SCHED) && out_free &&
                       (count_ff < odt_pkg::TABLE_MAX);

   assign new_entry.deadline = now_ff + delay_ff;
   assign new_entry.task_id  = id_ff;

   // per-cell control decode
   always_comb begin
      for (int j = 0; j < odt_pkg::MAX_TASKS; j++) begin
         cell_ctl[j].take_new  = sched_load && (count_ff == odt_pkg::COUNT_W'(j));
         cell_ctl[j].take_head = scan_step && !head_due &&
                                 (tail_pos == odt_pkg::COUNT_W'(j));
         cell_ctl[j].shift     = scan_step;
      end
   end

   for (genvar g = 0; g < odt_pkg::MAX_TASKS; g++) begin : g_cell
      if (g == odt_pkg::MAX_TASKS - 1) begin : g_end
         assign cell_right[g] = cell_entry[g];
      end else begin : g_mid
         assign cell_right[g] = cell_entry[g+1];
      end

      odt_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .new_in    (new_entry),
         .head_in   (head_entry),
         .right_in  (cell_right[g]),
         .entry_out (cell_entry[g])
      );
   end

   always_comb begin
      state_in        = state_ff;
      now_in          = now_ff;
      delay_in        = delay_ff;
      id_in           = id_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      kept_in         = kept_ff;
      pend_valid_in   = pend_valid_ff;
      pend_id_in      = pend_id_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_fired_in    = rsp_fired_ff;
      rsp_task_out_in = rsp_task_out_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in        = req_now;
               id_in         = req_task_id;
               // millisecond delays scale here, the add happens in ST_SCHED
               delay_in      = (req_op == odt_pkg::OP_SCHED_MS) ?
                               odt_pkg::TIME_W'(req_delay * odt_pkg::MS_TO_US) :
                               req_delay;
               pend_valid_in = 1'b0;
               unique case (req_op) inside
                  odt_pkg::OP_SCHED_US, odt_pkg::OP_SCHED_MS: begin
                     state_in = ST_SCHED;
                  end
                  odt_pkg::OP_RUN: begin
                     remain_in = count_ff;
                     kept_in   = '0;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     // unused code: empty scan keeps every entry
                     remain_in = '0;
                     kept_in   = count_ff;
                     state_in  = ST_SCAN;
                  end
               endcase
            end
         end

         ST_SCHED: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = sched_load;
               rsp_fired_in    = 1'b0;
               rsp_task_out_in = '0;
               rsp_last_in     = 1'b1;
               if (sched_load) begin
                  count_in = count_ff + odt_pkg::COUNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (remain_ff != '0) begin
               if (scan_step) begin
                  remain_in = remain_ff - odt_pkg::COUNT_W'(1);
                  if (head_due) begin
                     // release the held task, keep this one back
                     if (pend_valid_ff) begin
                        rsp_valid_in    = 1'b1;
                        rsp_accepted_in = 1'b0;
                        rsp_fired_in    = 1'b1;
                        rsp_task_out_in = pend_id_ff;
                        rsp_last_in     = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_id_in    = head_entry.task_id;
                  end else begin
                     kept_in = kept_ff + odt_pkg::COUNT_W'(1);
                  end
               end
            end else if (out_free) begin
               // closing transaction: last due task, or an empty one
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_fired_in    = pend_valid_ff;
               rsp_task_out_in = pend_valid_ff ? pend_id_ff : '0;
               rsp_last_in     = 1'b1;
               pend_valid_in   = 1'b0;
               count_in        = kept_ff;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         kept_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         kept_ff       <= kept_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      delay_ff        <= delay_in;
      id_ff           <= id_in;
      pend_id_ff      <= pend_id_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_fired_ff    <= rsp_fired_in;
      rsp_task_out_ff <= rsp_task_out_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_fired    = rsp_fired_ff;
   assign rsp_task_out = rsp_task_out_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ rtl/odt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_cell
// One table slot: loads a new entry, the head entry, or its right neighbor.
// ----------------------------------------------------------------------------
module odt_cell (
   input  logic                      clock,
   input  odt_pkg::odt_cell_ctl_type ctl,
   input  odt_pkg::odt_entry_type    new_in,
   input  odt_pkg::odt_entry_type    head_in,
   input  odt_pkg::odt_entry_type    right_in,
   output odt_pkg::odt_entry_type    entry_out
);

   odt_pkg::odt_entry_type entry_ff;
   odt_pkg::odt_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.take_new) begin
         entry_in = new_in;
      end else if (ctl.take_head) begin
         entry_in = head_in;
      end else if (ctl.shift) begin
         entry_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

@@ sim/odt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odt_checker
// Watches both channels of the deadline table, keeps its own copy of the
// table, predicts every result and compares accepted results in order.
// ----------------------------------------------------------------------------
module odt_checker (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [odt_pkg::OP_W-1:0]    req_op,
   input  logic [odt_pkg::TIME_W-1:0]  req_now,
   input  logic [odt_pkg::ID_W-1:0]    req_task_id,
   input  logic [odt_pkg::TIME_W-1:0]  req_delay,

   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_accepted,
   input  logic                        rsp_fired,
   input  logic [odt_pkg::ID_W-1:0]    rsp_task_out,
   input  logic                        rsp_last,

   output int                          fail_count,
   output int                          pending,
   output int                          released_count,
   output int                          refused_count
);

   typedef struct packed {
      logic                     accepted;
      logic                     fired;
      logic [odt_pkg::ID_W-1:0] task_out;
      logic                     last;
   } table_result_type;

   logic [odt_pkg::TIME_W-1:0] slot_due [odt_pkg::MAX_TASKS];
   logic [odt_pkg::ID_W-1:0]   slot_id  [odt_pkg::MAX_TASKS];
   int                         fill = 0;
   table_result_type           awaited_results [$];

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      fail_count++;
      // keep the log short when the block is badly broken
      if (fail_count <= 40) begin
         $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
      end
   endtask

   task automatic await_result(input logic acc, input logic fired,
                               input logic [odt_pkg::ID_W-1:0] id, input logic last);
      table_result_type r;
      r.accepted = acc;
      r.fired    = fired;
      r.task_out = id;
      r.last     = last;
      awaited_results.push_back(r);
   endtask

   task automatic predict_request(input logic [odt_pkg::OP_W-1:0] op,
                                  input logic [odt_pkg::TIME_W-1:0] now,
                                  input logic [odt_pkg::ID_W-1:0] id,
                                  input logic [odt_pkg::TIME_W-1:0] delay);
      logic [odt_pkg::TIME_W-1:0] span;
      int                         kept;
      int                         due_total;
      int                         released;
      case (op) inside
         odt_pkg::OP_SCHED_US, odt_pkg::OP_SCHED_MS: begin
            span = (op == odt_pkg::OP_SCHED_MS) ? delay * odt_pkg::MS_TO_US : delay;
            if (fill < odt_pkg::MAX_TASKS) begin
               slot_due[fill] = now + span;
               slot_id[fill]  = id;
               fill++;
               await_result(1'b1, 1'b0, '0, 1'b1);
            end else begin
               refused_count++;
               await_result(1'b0, 1'b0, '0, 1'b1);
            end
         end
         odt_pkg::OP_RUN: begin
            due_total = 0;
            for (int i = 0; i < fill; i++) begin
               if (now >= slot_due[i]) due_total++;
            end
            kept     = 0;
            released = 0;
            for (int i = 0; i < fill; i++) begin
               if (now >= slot_due[i]) begin
                  released++;
                  await_result(1'b0, 1'b1, slot_id[i], released == due_total);
               end else begin
                  slot_due[kept] = slot_due[i];
                  slot_id[kept]  = slot_id[i];
                  kept++;
               end
            end
            fill = kept;
            released_count += due_total;
            if (due_total == 0) await_result(1'b0, 1'b0, '0, 1'b1);
         end
         default: begin
            await_result(1'b0, 1'b0, '0, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         fill = 0;
         fail_count     = 0;
         released_count = 0;
         refused_count  = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_op, req_now, req_task_id, req_delay);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing awaited, task_out",
                               32'(rsp_task_out), 32'd0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 32'(rsp_accepted), 32'(want.accepted));
               if (rsp_fired !== want.fired)
                  report_mismatch("fired", 32'(rsp_fired), 32'(want.fired));
               if (rsp_task_out !== want.task_out)
                  report_mismatch("task_out", 32'(rsp_task_out), 32'(want.task_out));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
      pending <= awaited_results.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the one-shot deadline table with directed and random transactions,
// under bursty requests and a stalling result side; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 350;

   logic                       clock;
   logic                       reset       = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic [odt_pkg::OP_W-1:0]   req_op      = odt_pkg::OP_NONE;
   logic [odt_pkg::TIME_W-1:0] req_now     = '0;
   logic [odt_pkg::ID_W-1:0]   req_task_id = '0;
   logic [odt_pkg::TIME_W-1:0] req_delay   = '0;

   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic                       rsp_accepted;
   logic                       rsp_fired;
   logic [odt_pkg::ID_W-1:0]   rsp_task_out;
   logic                       rsp_last;

   int                fail_count;
   int                pending;
   int                released_count;
   int                refused_count;

   int                cycle_count = 0;
   int                items_sent  = 0;
   int                burst_left  = 0;

   // result side stall pattern state
   int                stall_mode  = 0;
   int                stall_left  = 0;
   int                stall_phase = 0;

   one_shot_deadline_table_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_now      (req_now),
      .req_task_id  (req_task_id),
      .req_delay    (req_delay),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_fired    (rsp_fired),
      .rsp_task_out (rsp_task_out),
      .rsp_last     (rsp_last)
   );

   odt_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_now        (req_now),
      .req_task_id    (req_task_id),
      .req_delay      (req_delay),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_fired      (rsp_fired),
      .rsp_task_out   (rsp_task_out),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending        (pending),
      .released_count (released_count),
      .refused_count  (refused_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
         $display("one_shot_deadline_table_core test failed");
         $finish;
      end
   end

   // result side: each mode holds for a random stretch
   //   mode 0 always ready, mode 1 coin flip, mode 2 ready when the phase is a multiple of five
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= (stall_phase % 5 == 0);
      endcase
   end

   // one request transaction; valid stays up across a burst, drops for a gap
   task automatic send_item(input logic [odt_pkg::OP_W-1:0] op,
                            input logic [odt_pkg::TIME_W-1:0] at_time,
                            input logic [odt_pkg::ID_W-1:0] id,
                            input logic [odt_pkg::TIME_W-1:0] delay);
      int gap;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_now     <= at_time;
      req_task_id <= id;
      req_delay   <= delay;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // mostly short bursts, now and then a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic directed_part();
      // empty table, unused op code, then the field extremes
      send_item(odt_pkg::OP_RUN, 32'h0000_0000, 8'h00, 32'h0000_0000);
      send_item(odt_pkg::OP_NONE, '1, '1, '1);
      send_item(odt_pkg::OP_SCHED_US, 32'h0000_0000, 8'h00, 32'h0000_0000);
      // millisecond scaling wraps the product and the sum
      send_item(odt_pkg::OP_SCHED_MS, '1, '1, '1);
      // deadline wraps past zero and is due at once
      send_item(odt_pkg::OP_SCHED_US, 32'hFFFF_FFF0, 8'h5A, 32'h0000_0020);
      send_item(odt_pkg::OP_RUN, 32'h0000_0100, 8'h00, 32'h0000_0000);
      // fill the table, last one is refused; the odd-indexed tasks come due first
      for (int i = 0; i < odt_pkg::MAX_TASKS; i++) begin
         send_item(odt_pkg::OP_SCHED_US, 32'h0000_1000, odt_pkg::ID_W'(8'hA0 + i),
                   (i % 2 == 1) ? 32'h0000_0010 : 32'h8000_0000);
      end
      // release from the middle so later entries close the gaps
      send_item(odt_pkg::OP_RUN, 32'h0000_2000, 8'h33, 32'h1234_5678);
      send_item(odt_pkg::OP_RUN, '1, 8'h00, 32'h0000_0000);
   endtask

   task automatic random_part();
      logic [odt_pkg::TIME_W-1:0] clock_now;
      logic [odt_pkg::OP_W-1:0]   op;
      int                         pick;
      int                         counted;
      clock_now = $urandom;
      counted   = 0;
      while (counted < RANDOM_ITEMS) begin
         clock_now = clock_now + $urandom_range(0, 300);
         // occasional jump in time, which exercises wrapped deadlines
         if ($urandom_range(0, 49) == 0) clock_now = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_item(odt_pkg::OP_SCHED_US, clock_now, odt_pkg::ID_W'($urandom),
                      ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 3000));
         end else if (pick < 58) begin
            send_item(odt_pkg::OP_SCHED_MS, clock_now, odt_pkg::ID_W'($urandom),
                      ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4));
         end else if (pick < 90) begin
            // some runs flush the table so a backward jump cannot jam it
            send_item(odt_pkg::OP_RUN, ($urandom_range(0, 9) == 0) ? '1 : clock_now,
                      odt_pkg::ID_W'($urandom), $urandom);
         end else if (pick < 95) begin
            send_item(odt_pkg::OP_NONE, $urandom, odt_pkg::ID_W'($urandom), $urandom);
         end else begin
            // noise: any op, any field
            op = odt_pkg::OP_W'($urandom_range(0, 3));
            send_item(op, $urandom, odt_pkg::ID_W'($urandom), $urandom);
         end
         counted++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      random_part();
      req_valid <= 1'b0;
      // the count seen here already includes the last accepted transaction
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // a full scan plus stalls, then look for stray results
      repeat (60) @(posedge clock);
      $display("covered %0d request transactions in %0d cycles", items_sent, cycle_count);
      $display("released %0d due tasks, refused %0d schedules on a full table",
               released_count, refused_count);
      if (fail_count == 0) begin
         $display("one_shot_deadline_table_core test passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("one_shot_deadline_table_core test failed");
      end
      $finish;
   end

endmodule
